/* hw/rtl/htd_pkg.sv */
// htd_pkg: shared types and constants of the huffman tree decoder
// node record, input and result words, command and status codes; no dependencies
package htd_pkg;

  localparam int unsigned NODE_COUNT   = 255;
  localparam int unsigned NODE_W       = $clog2(NODE_COUNT);
  localparam int unsigned SYM_W        = 7;
  localparam int unsigned MAX_CODE_LEN = 32;
  localparam int unsigned CODE_W       = 32;
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned VBITS_W      = 4;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned STATUS_W     = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DECODE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LOADFAIL = 2'd2;

  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic [SYM_W-1:0]  sym;
  } node_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [SYM_W-1:0]   symbol;
    logic [CODE_W-1:0]  code_bits;
    logic [LEN_W-1:0]   code_length;
    logic [BYTE_W-1:0]  data_byte;
    logic [VBITS_W-1:0] valid_bits;
  } req_t;

  typedef struct packed {
    logic [SYM_W-1:0]    decoded_symbol;
    logic [STATUS_W-1:0] status;
    logic                last;
  } res_t;

endpackage

/* hw/rtl/htd_node_ram.sv */
// htd_node_ram: node store of the code tree, one write and one read port
// read data registered, valid the cycle after a read enable; uses htd_pkg
module htd_node_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [htd_pkg::NODE_W-1:0] waddr_i,
  input  htd_pkg::node_t            wdata_i,
  input  logic                      re_i,
  input  logic [htd_pkg::NODE_W-1:0] raddr_i,
  output htd_pkg::node_t            rdata_o
);

  htd_pkg::node_t mem [htd_pkg::NODE_COUNT];
  htd_pkg::node_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/htd_result_buf.sv */
// htd_result_buf: holding stage and output register for result words
// a word is held until the next one or the end of its item fixes its last flag; uses htd_pkg
module htd_result_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  htd_pkg::res_t push_data_i,
  output logic          push_ready_o,
  input  logic          close_i,
  output logic          out_valid_o,
  output htd_pkg::res_t out_data_o,
  input  logic          out_stall_i
);

  logic          held_v_q, held_v_d;
  htd_pkg::res_t held_q, held_d;
  logic          out_v_q, out_v_d;
  htd_pkg::res_t out_q, out_d;
  logic          out_free;
  logic          move;

  assign out_free     = !out_v_q || !out_stall_i;
  assign move         = held_v_q && out_free && (held_q.last || push_valid_i);
  assign push_ready_o = !held_v_q || out_free;

  always_comb begin
    held_v_d = held_v_q;
    held_d   = held_q;
    out_v_d  = out_v_q && out_stall_i;
    out_d    = out_q;
    if (move) begin
      out_v_d = 1'b1;
      out_d   = held_q;
    end
    if (push_valid_i && push_ready_o) begin
      held_v_d = 1'b1;
      held_d   = push_data_i;
    end else if (move) begin
      held_v_d = 1'b0;
    end else if (close_i && held_v_q) begin
      held_d.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      held_v_q <= held_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

/* hw/rtl/huffman_tree_decoder.sv */
// huffman_tree_decoder: code tree walker over htd_node_ram, result words via htd_result_buf
// decode: word taken in idle; a walk step per bit, an emit per leaf, a close if bits end inside
// load: idle, a walk step per path node found, a link, a write per new node; clear, unused cmd: idle
// rate set by the dependent node-store read per code bit, plus any output stall on a result
// a result moves out once its last flag is known; results drain while the next word runs
// reset: root node (flip-flops) reads empty, one free node counter at 1, walk at root; no clearing pass
module huffman_tree_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  htd_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output htd_pkg::res_t out_data_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DWALK = 6'b000010,
    ST_LWALK = 6'b000100,
    ST_LLINK = 6'b001000,
    ST_LNEW  = 6'b010000,
    ST_LFAIL = 6'b100000
  } state_e;

  localparam int unsigned NW = htd_pkg::NODE_W;

  // pick the child on one branch of a node
  function automatic logic [htd_pkg::NODE_W-1:0] child_of(htd_pkg::node_t n, logic bit_v);
    return bit_v ? n.right : n.left;
  endfunction

  // set the child on one branch of a node
  function automatic htd_pkg::node_t set_child(htd_pkg::node_t n, logic bit_v,
                                               logic [htd_pkg::NODE_W-1:0] c);
    htd_pkg::node_t r;
    r = n;
    if (bit_v) begin
      r.right = c;
    end else begin
      r.left = c;
    end
    return r;
  endfunction

  state_e                        state_q, state_d;
  htd_pkg::node_t                root_q, root_d;     // root kept in flops, never in the store
  logic [NW-1:0]                 nfree_q, nfree_d;   // next free node index
  logic [NW-1:0]                 cur_q, cur_d;       // walk position between decode words
  logic [NW-1:0]                 node_q, node_d;     // node being looked at
  logic                          from_mem_q, from_mem_d; // its record sits on the ram read port
  logic                          chk_q, chk_d;       // record just fetched still needs its leaf test
  htd_pkg::node_t                ent_q, ent_d;       // record of the node where a load branches off
  logic [htd_pkg::SYM_W-1:0]     sym_q, sym_d;
  logic [htd_pkg::CODE_W-1:0]    code_q, code_d;     // load path, next bit at the msb
  logic [htd_pkg::LEN_W-1:0]     left_q, left_d;     // path bits still to walk
  logic [htd_pkg::BYTE_W-1:0]    byte_q, byte_d;     // data bits, next bit at the msb
  logic [htd_pkg::VBITS_W-1:0]   cnt_q, cnt_d;       // data bits still to walk

  htd_pkg::node_t                ent;
  logic                          leaf;
  logic                          dbit;
  logic                          lbit;
  logic [NW-1:0]                 dchild;
  logic [NW-1:0]                 lchild;
  logic                          overflow;
  logic [htd_pkg::VBITS_W-1:0]   in_cnt;
  logic [htd_pkg::LEN_W-1:0]     align;
  logic [NW-1:0]                 nfree_inc;

  logic                          ram_we;
  logic [NW-1:0]                 ram_waddr;
  htd_pkg::node_t                ram_wdata;
  logic                          ram_re;
  logic [NW-1:0]                 ram_raddr;
  htd_pkg::node_t                ram_rdata;

  logic                          push_v;
  htd_pkg::res_t                 push_res;
  logic                          push_ready;
  logic                          close;

  // current node record: from the read port once fetched, else the root flops
  assign ent       = from_mem_q ? ram_rdata : root_q;
  assign leaf      = (ent.left == '0) && (ent.right == '0);
  assign dbit      = byte_q[htd_pkg::BYTE_W-1];
  assign lbit      = code_q[htd_pkg::CODE_W-1];
  assign dchild    = child_of(ent, dbit);
  assign lchild    = child_of(ent, lbit);
  assign nfree_inc = nfree_q + NW'(1);
  // load is all or nothing: every remaining path bit needs a new node
  assign overflow  = ((NW+1)'(nfree_q) + (NW+1)'(left_q)) > (NW+1)'(htd_pkg::NODE_COUNT);
  assign in_cnt    = (in_data_i.valid_bits > htd_pkg::VBITS_W'(htd_pkg::BYTE_W))
                   ? htd_pkg::VBITS_W'(htd_pkg::BYTE_W) : in_data_i.valid_bits;
  assign align     = htd_pkg::LEN_W'(htd_pkg::CODE_W) - in_data_i.code_length;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d    = state_q;
    root_d     = root_q;
    nfree_d    = nfree_q;
    cur_d      = cur_q;
    node_d     = node_q;
    from_mem_d = from_mem_q;
    chk_d      = chk_q;
    ent_d      = ent_q;
    sym_d      = sym_q;
    code_d     = code_q;
    left_d     = left_q;
    byte_d     = byte_q;
    cnt_d      = cnt_q;
    ram_we     = 1'b0;
    ram_waddr  = node_q;
    ram_wdata  = ent;
    ram_re     = 1'b0;
    ram_raddr  = cur_q;
    push_v     = 1'b0;
    push_res   = '0;
    close      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.cmd)
            htd_pkg::CMD_CLEAR: begin
              root_d  = '0;
              nfree_d = NW'(1);
              cur_d   = '0;
            end
            htd_pkg::CMD_LOAD: begin
              sym_d = in_data_i.symbol;
              if (in_data_i.code_length > htd_pkg::LEN_W'(htd_pkg::MAX_CODE_LEN)) begin
                state_d = ST_LFAIL;
              end else begin
                code_d     = in_data_i.code_bits << align;
                left_d     = in_data_i.code_length;
                node_d     = '0;
                from_mem_d = 1'b0;
                state_d    = ST_LWALK;
              end
            end
            htd_pkg::CMD_DECODE: begin
              if (in_cnt != '0) begin
                byte_d     = in_data_i.data_byte;
                cnt_d      = in_cnt;
                node_d     = cur_q;
                chk_d      = 1'b0;
                // resume inside the tree: refetch, a load may have grown this node
                from_mem_d = (cur_q != '0);
                ram_re     = (cur_q != '0);
                ram_raddr  = cur_q;
                state_d    = ST_DWALK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_DWALK: begin
        if (chk_q && leaf) begin
          // leaf reached: one symbol out, back to the root, no bit this cycle
          push_v   = 1'b1;
          push_res = '{decoded_symbol: ent.sym, status: htd_pkg::ST_OK,
                       last: (cnt_q == '0)};
          if (push_ready) begin
            chk_d      = 1'b0;
            node_d     = '0;
            from_mem_d = 1'b0;
            if (cnt_q == '0) begin
              cur_d   = '0;
              state_d = ST_IDLE;
            end
          end
        end else if (cnt_q == '0) begin
          // bits used up inside the tree: keep the position for the next word
          close   = 1'b1;
          cur_d   = node_q;
          chk_d   = 1'b0;
          state_d = ST_IDLE;
        end else if (dchild == '0) begin
          // empty branch
          push_v   = 1'b1;
          push_res = '{decoded_symbol: '0, status: htd_pkg::ST_EMPTY,
                       last: (cnt_q == htd_pkg::VBITS_W'(1))};
          if (push_ready) begin
            node_d     = '0;
            from_mem_d = 1'b0;
            chk_d      = 1'b0;
            byte_d     = {byte_q[htd_pkg::BYTE_W-2:0], 1'b0};
            cnt_d      = cnt_q - htd_pkg::VBITS_W'(1);
            if (cnt_q == htd_pkg::VBITS_W'(1)) begin
              cur_d   = '0;
              state_d = ST_IDLE;
            end
          end
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = dchild;
          node_d     = dchild;
          from_mem_d = 1'b1;
          chk_d      = 1'b1;
          byte_d     = {byte_q[htd_pkg::BYTE_W-2:0], 1'b0};
          cnt_d      = cnt_q - htd_pkg::VBITS_W'(1);
        end
      end

      ST_LWALK: begin
        if (left_q == '0) begin
          // whole path exists: only the end node's symbol changes
          if (node_q == '0) begin
            root_d.sym = sym_q;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = node_q;
            ram_wdata = '{left: ent.left, right: ent.right, sym: sym_q};
          end
          state_d = ST_IDLE;
        end else if (lchild != '0) begin
          ram_re     = 1'b1;
          ram_raddr  = lchild;
          node_d     = lchild;
          from_mem_d = 1'b1;
          code_d     = {code_q[htd_pkg::CODE_W-2:0], 1'b0};
          left_d     = left_q - htd_pkg::LEN_W'(1);
        end else if (overflow) begin
          state_d = ST_LFAIL;
        end else begin
          ent_d   = ent;
          state_d = ST_LLINK;
        end
      end

      ST_LLINK: begin
        // hang the first new node on the branch point
        if (node_q == '0) begin
          root_d = set_child(ent_q, lbit, nfree_q);
        end else begin
          ram_we    = 1'b1;
          ram_waddr = node_q;
          ram_wdata = set_child(ent_q, lbit, nfree_q);
        end
        code_d  = {code_q[htd_pkg::CODE_W-2:0], 1'b0};
        left_d  = left_q - htd_pkg::LEN_W'(1);
        state_d = ST_LNEW;
      end

      ST_LNEW: begin
        // new nodes take consecutive indices, each but the last pointing at the next
        ram_we    = 1'b1;
        ram_waddr = nfree_q;
        nfree_d   = nfree_inc;
        if (left_q == '0) begin
          ram_wdata = '{left: '0, right: '0, sym: sym_q};
          state_d   = ST_IDLE;
        end else begin
          ram_wdata = set_child('0, lbit, nfree_inc);
          code_d    = {code_q[htd_pkg::CODE_W-2:0], 1'b0};
          left_d    = left_q - htd_pkg::LEN_W'(1);
        end
      end

      ST_LFAIL: begin
        push_v   = 1'b1;
        push_res = '{decoded_symbol: '0, status: htd_pkg::ST_LOADFAIL, last: 1'b1};
        if (push_ready) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      root_q     <= '0;
      nfree_q    <= NW'(1);
      cur_q      <= '0;
      node_q     <= '0;
      from_mem_q <= 1'b0;
      chk_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      root_q     <= root_d;
      nfree_q    <= nfree_d;
      cur_q      <= cur_d;
      node_q     <= node_d;
      from_mem_q <= from_mem_d;
      chk_q      <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    sym_q  <= sym_d;
    code_q <= code_d;
    left_q <= left_d;
    byte_q <= byte_d;
    cnt_q  <= cnt_d;
  end

  // reads and writes fall in separate phases of a word, so no same-entry overlap
  htd_node_ram u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  htd_result_buf u_result_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_v),
    .push_data_i  (push_res),
    .push_ready_o (push_ready),
    .close_i      (close),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .out_stall_i  (out_stall_i)
  );

  // a new node is only ever written inside the store
  a_new_node_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LNEW) |-> (nfree_q < NW'(htd_pkg::NODE_COUNT)))
    else $error("new node index past end of node store");

  // a leaf test only happens on a record fetched from the store
  a_chk_from_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_q |-> from_mem_q)
    else $error("leaf test without fetched record");

  // the root never comes from the store
  a_root_not_fetched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    from_mem_q && (state_q == ST_LWALK || state_q == ST_DWALK) |-> (node_q != '0))
    else $error("root record taken from node store");

  // every load failure word leaves the walk idle next cycle once taken
  a_fail_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LFAIL) && push_ready |=> (state_q == ST_IDLE))
    else $error("load failure not completed");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking regression of huffman_tree_decoder, tree loads and byte decodes
// depends on htd_pkg for word types and codes; holds its own tree walker as predictor
module testbench;
  import htd_pkg::*;

  localparam int unsigned HALF_PERIOD   = 5;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned RANDOM_WORDS  = 260;
  localparam int unsigned DRAIN_CYCLES  = 120;
  localparam int unsigned RUN_LIMIT_NS  = 5_000_000;
  localparam int unsigned SYMBOL_COUNT  = 128;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  res_t out_data_o;

  huffman_tree_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // shadow copy of the code tree and the walk position
  logic [NODE_W-1:0] node_left  [NODE_COUNT];
  logic [NODE_W-1:0] node_right [NODE_COUNT];
  logic [SYM_W-1:0]  node_sym   [NODE_COUNT];
  int unsigned       free_node;
  int unsigned       walk_node;

  req_t word_backlog [$];   // words still to be offered
  res_t due_results  [$];   // results predicted but not yet seen
  res_t oldest_due;

  int unsigned counted_words = 0;   // words that do real work, ignored ones excluded
  int unsigned words_taken   = 0;
  int unsigned errors        = 0;
  int unsigned n_symbols     = 0;
  int unsigned n_empty       = 0;
  int unsigned n_loadfail    = 0;
  int unsigned gap_left      = 0;
  int unsigned stall_left    = 0;
  bit          calm          = 1'b0;   // no gaps and no stalls while set

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // empty tree: bare root, allocation restarts after it, walk back at the root
  function automatic void tree_clear();
    node_left[0]  = '0;
    node_right[0] = '0;
    node_sym[0]   = '0;
    free_node     = 1;
    walk_node     = 0;
  endfunction

  // a zero child index means an empty branch, the root is nobody's child
  function automatic int unsigned child_of(int unsigned node, logic branch);
    return branch ? 32'(node_right[node]) : 32'(node_left[node]);
  endfunction

  function automatic void add_result(logic [SYM_W-1:0] sym, logic [STATUS_W-1:0] status);
    res_t r;
    r.decoded_symbol = sym;
    r.status         = status;
    r.last           = 1'b0;
    due_results = {due_results, r};
  endfunction

  // applies one accepted word to the shadow tree and queues what it should emit
  function automatic void tree_apply(req_t w);
    int unsigned node, need, len, cnt, c, i, first;
    logic branch;
    first = due_results.size();
    case (w.cmd)
      CMD_CLEAR: tree_clear();
      CMD_LOAD: begin
        len  = 32'(w.code_length);
        need = 0;
        node = 0;
        // first pass: how many new nodes the path needs
        if (len <= MAX_CODE_LEN && len <= CODE_W) begin
          for (i = len; i > 0; i--) begin
            c = child_of(node, w.code_bits[i-1]);
            if (c == 0) begin
              need = i;
              break;
            end
            node = c;
          end
        end
        // too long or no room: all or nothing, tree left alone
        if (len > MAX_CODE_LEN || len > CODE_W || free_node + need > NODE_COUNT) begin
          add_result('0, ST_LOADFAIL);
        end else begin
          node = 0;
          for (i = len; i > 0; i--) begin
            branch = w.code_bits[i-1];
            c = child_of(node, branch);
            if (c == 0) begin
              c = free_node;
              free_node++;
              node_left[c]  = '0;
              node_right[c] = '0;
              node_sym[c]   = '0;
              if (branch) begin
                node_right[node] = NODE_W'(c);
              end else begin
                node_left[node] = NODE_W'(c);
              end
            end
            node = c;
          end
          // a zero-length load lands on the root, which is never taken as a leaf
          node_sym[node] = SYM_W'(32'(w.symbol) % SYMBOL_COUNT);
        end
      end
      CMD_DECODE: begin
        cnt = (32'(w.valid_bits) > BYTE_W) ? BYTE_W : 32'(w.valid_bits);
        for (i = 0; i < cnt; i++) begin
          c = child_of(walk_node, w.data_byte[BYTE_W-1-i]);
          if (c == 0 || c >= NODE_COUNT) begin
            add_result('0, ST_EMPTY);
            walk_node = 0;
          end else if (node_left[c] == '0 && node_right[c] == '0) begin
            add_result(node_sym[c], ST_OK);
            walk_node = 0;
          end else begin
            walk_node = c;
          end
        end
      end
      default: ;   // unused command does nothing
    endcase
    if (due_results.size() > first) begin
      due_results[due_results.size()-1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // gap or stall length: mostly none or short, now and then long
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // fields that the command does not use carry random junk
  function automatic req_t scrambled_word(logic [CMD_W-1:0] cmd);
    req_t w;
    w.cmd         = cmd;
    w.symbol      = SYM_W'($urandom);
    w.code_bits   = $urandom;
    w.code_length = LEN_W'($urandom);
    w.data_byte   = BYTE_W'($urandom);
    w.valid_bits  = VBITS_W'($urandom);
    return w;
  endfunction

  function automatic void push_word(req_t w);
    word_backlog = {word_backlog, w};
    if (!(w.cmd == CMD_UNUSED || (w.cmd == CMD_DECODE && w.valid_bits == '0))) begin
      counted_words++;
    end
  endfunction

  function automatic void push_clear();
    push_word(scrambled_word(CMD_CLEAR));
  endfunction

  // path bits above the length are junk, the block must ignore them
  function automatic void push_load(logic [SYM_W-1:0] sym, logic [CODE_W-1:0] path,
                                    int unsigned len);
    req_t w;
    logic [63:0] keep;
    w = scrambled_word(CMD_LOAD);
    keep = (len >= CODE_W) ? 64'hFFFF_FFFF : ((64'd1 << len) - 64'd1);
    w.symbol      = sym;
    w.code_length = LEN_W'(len);
    w.code_bits   = (w.code_bits & ~keep[CODE_W-1:0]) | (path & keep[CODE_W-1:0]);
    push_word(w);
  endfunction

  function automatic void push_decode(logic [BYTE_W-1:0] data, int unsigned vbits);
    req_t w;
    w = scrambled_word(CMD_DECODE);
    w.data_byte  = data;
    w.valid_bits = VBITS_W'(vbits);
    push_word(w);
  endfunction

  // random prefix code: load it, then decode a packed stream of its codes
  function automatic void code_phase();
    logic [CODE_W-1:0] path_v [$];
    int unsigned       path_n [$];
    logic [SYM_W-1:0]  path_sym [$];
    bit                stream [$];
    bit                deep;
    int unsigned       leaves, pick, off, idx, vb, k, n;
    logic [CODE_W-1:0] v;
    logic [BYTE_W-1:0] data;
    // deep trees grow as a comb so walks span several bytes
    deep   = ($urandom_range(7) == 0);
    leaves = deep ? $urandom_range(6, 20) : $urandom_range(2, 12);
    path_v = '{32'd0, 32'd1};
    path_n = '{1, 1};
    while (path_v.size() < leaves) begin
      pick = deep ? path_v.size() - 1 : $urandom_range(path_v.size() - 1);
      v = path_v[pick];
      n = path_n[pick];
      if (deep || n < 8) begin
        path_v.delete(pick);
        path_n.delete(pick);
        path_v = {path_v, {v[CODE_W-2:0], 1'b0}};
        path_n = {path_n, n + 1};
        path_v = {path_v, {v[CODE_W-2:0], 1'b1}};
        path_n = {path_n, n + 1};
      end
    end
    foreach (path_v[i]) path_sym = {path_sym, SYM_W'($urandom)};
    // sometimes built on top of the previous tree
    if ($urandom_range(5) != 0) push_clear();
    off = $urandom_range(path_v.size() - 1);
    for (k = 0; k < path_v.size(); k++) begin
      idx = (k + off) % path_v.size();
      // an occasional missing code leaves an empty branch behind
      if ($urandom_range(11) != 0) push_load(path_sym[idx], path_v[idx], path_n[idx]);
      if ($urandom_range(14) == 0) push_decode(BYTE_W'($urandom), 0);
    end
    repeat ($urandom_range(1, 24)) begin
      idx = $urandom_range(path_v.size() - 1);
      for (k = path_n[idx]; k > 0; k--) stream = {stream, path_v[idx][k-1]};
    end
    // final byte carries only the bits left over
    while (stream.size() != 0) begin
      vb   = (stream.size() < BYTE_W) ? stream.size() : BYTE_W;
      data = BYTE_W'($urandom);
      for (k = 0; k < vb; k++) data[BYTE_W-1-k] = stream.pop_front();
      if (vb == BYTE_W && $urandom_range(9) == 0) vb = $urandom_range(9, 15);
      push_decode(data, vb);
    end
  endfunction

  // long random paths until the node store runs out
  function automatic void overflow_phase();
    push_clear();
    repeat (11) push_load(SYM_W'($urandom), $urandom, CODE_W);
    push_load(SYM_W'($urandom), $urandom, $urandom_range(1, 8));
    repeat ($urandom_range(2, 5)) push_decode(BYTE_W'($urandom), BYTE_W);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers backlog words, holds each one until it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        tree_apply(in_data_i);
        words_taken++;
        if ($urandom_range(49) == 0) calm <= !calm;
      end
      // a stalled word stays put
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (word_backlog.size() != 0) begin
          in_data_i  <= word_backlog.pop_front();
          in_valid_i <= 1'b1;
          gap_left   <= pick_idle();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random stall bursts, each result checked against the oldest due one
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: decoded_symbol %0d status %0d last %0d",
                 out_data_o.decoded_symbol, out_data_o.status, out_data_o.last);
          errors++;
        end else begin
          oldest_due = due_results.pop_front();
          if (out_data_o.decoded_symbol !== oldest_due.decoded_symbol) begin
            $error("decoded_symbol mismatch: expected %0d actual %0d",
                   oldest_due.decoded_symbol, out_data_o.decoded_symbol);
            errors++;
          end
          if (out_data_o.status !== oldest_due.status) begin
            $error("status mismatch: expected %0d actual %0d",
                   oldest_due.status, out_data_o.status);
            errors++;
          end
          if (out_data_o.last !== oldest_due.last) begin
            $error("last mismatch: expected %0d actual %0d",
                   oldest_due.last, out_data_o.last);
            errors++;
          end
          case (oldest_due.status)
            ST_OK:    n_symbols++;
            ST_EMPTY: n_empty++;
            default:  n_loadfail++;
          endcase
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if (!calm && $urandom_range(3) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= pick_idle();
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned target;
    tree_clear();

    // walk of the bare tree after reset: every bit hits an empty branch
    push_decode(8'hA5, 8);
    // zero-length load writes the root only
    push_load(7'd127, '0, 0);
    // too long for the code limit
    push_load(7'd1, $urandom, 33);
    push_load(7'd2, $urandom, 63);
    // small code: 0, 10, 11
    push_load(7'd5, 32'b0, 1);
    push_load(7'd127, 32'b10, 2);
    push_load(7'd0, 32'b11, 2);
    push_decode(8'b0101_1010, 8);
    // walk right half way at the end of a byte, carried into the next
    push_decode(8'b1000_0000, 1);
    // valid bits above eight saturate
    push_decode(8'b1011_0000, 15);
    // ignored words
    push_decode(8'hFF, 0);
    push_word(scrambled_word(CMD_UNUSED));
    // leaf 0 grows a child, so 01 is now an empty branch
    push_load(7'd9, 32'b00, 2);
    push_decode(8'b0100_0000, 4);
    // load ending on an internal node only renames it
    push_load(7'd33, 32'b1, 1);
    // longest code, decoded across four bytes
    push_load(7'd64, 32'hFFFF_FFFF, 32);
    repeat (4) push_decode(8'hFF, 8);
    push_decode(8'h00, 8);
    // cleared tree is empty again
    push_clear();
    push_decode(8'h3C, 8);

    // random part: store overflow first, then a mix of phases
    target = counted_words + RANDOM_WORDS;
    overflow_phase();
    while (counted_words < target) begin
      case ($urandom_range(9))
        7: overflow_phase();
        8: begin
          // malformed and stray words
          repeat ($urandom_range(6, 12)) begin
            case ($urandom_range(4))
              0:       push_load(SYM_W'($urandom), $urandom, $urandom_range(0, 63));
              1:       push_decode(BYTE_W'($urandom), $urandom_range(0, 15));
              2:       push_word(scrambled_word(CMD_UNUSED));
              3:       push_load(SYM_W'($urandom), $urandom, 0);
              default: push_clear();
            endcase
          end
        end
        9: repeat ($urandom_range(2, 8)) push_decode(BYTE_W'($urandom), $urandom_range(1, 15));
        default: code_phase();
      endcase
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (word_backlog.size() != 0 || in_valid_i) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    // a trailing load may still be running, and stray results would show up here
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      errors++;
    end

    $display("ran %0d words through clears, loads and decodes (%0d doing work)",
             words_taken, counted_words);
    $display("checked %0d decoded symbols, %0d empty-branch and %0d failed-load results",
             n_symbols, n_empty, n_loadfail);
    if (errors == 0) begin
      $display("huffman_tree_decoder regression: pass");
    end else begin
      $display("huffman_tree_decoder regression: fail");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #RUN_LIMIT_NS;
    $display("huffman_tree_decoder regression: fail");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/htd_pkg.sv
hw/rtl/htd_node_ram.sv
hw/rtl/htd_result_buf.sv
hw/rtl/huffman_tree_decoder.sv
dv/testbench.sv
